/* hw/rtl/dbq_pkg.sv */
// Shared constants, types and the tanh table of the drive/biquad/mix/limiter block.
// No dependencies; every other file of the block but dbq_if.sv imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dbq_pkg;

  localparam int CHANNELS = 2;
  localparam int BANDS    = 4;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int COEF_N = 5 * BANDS;
  localparam int COEF_W = $clog2(COEF_N);

  // Accumulator of the shared multiply-accumulate unit.
  localparam int ACC_W = 60;

  localparam int UNITY16    = 65536;
  localparam int CLIP_KNEE  = 31130;
  localparam int CLIP_SPAN  = 1638;
  localparam int TANH_LIMIT = 131072;
  localparam int TEMP_KNEE  = 420;
  localparam int TEMP_OFS   = 320;
  localparam int THERM_NUM  = 6553600;

  // Rounding shifts used by the shared unit.
  localparam logic [4:0] SH_GAIN = 5'd12;
  localparam logic [4:0] SH_TANH = 5'd13;
  localparam logic [4:0] SH_CLIP = 5'd15;
  localparam logic [4:0] SH_Q16  = 5'd16;
  localparam logic [4:0] SH_BIQ  = 5'd20;

  typedef enum logic [2:0] {
    CFG_DRIVE  = 3'd0,
    CFG_WET    = 3'd1,
    CFG_MIX    = 3'd2,
    CFG_MASTER = 3'd3,
    CFG_TEMP   = 3'd4
  } cfg_idx_e;

  // One operation for the shared multiply-accumulate unit.
  typedef struct packed {
    logic                    en;
    logic                    clr;
    logic signed [ACC_W-1:0] init;
    logic signed [31:0]      a;
    logic signed [24:0]      b;
    logic [4:0]              shift;
  } mac_cmd_t;

  // tanh(k/4) in Q.15 for k = 0..16.
  function automatic logic [15:0] tanh_tab(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd8026;
      5'd2:    v = 16'd15143;
      5'd3:    v = 16'd20813;
      5'd4:    v = 16'd24957;
      5'd5:    v = 16'd27797;
      5'd6:    v = 16'd29660;
      5'd7:    v = 16'd30847;
      5'd8:    v = 16'd31589;
      5'd9:    v = 16'd32048;
      5'd10:   v = 16'd32329;
      5'd11:   v = 16'd32500;
      5'd12:   v = 16'd32606;
      5'd13:   v = 16'd32670;
      5'd14:   v = 16'd32708;
      5'd15:   v = 16'd32732;
      default: v = 16'd32746;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dbq_if.sv */
// Valid/ready channel interfaces of the block: sample input, result output, configuration.
// Standalone; payload widths follow the field list of the block.
`timescale 1ns / 1ps
`default_nettype none

interface dbq_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic               channel;
  logic signed [15:0] sample_in;
  logic [4:0]         coef_index;
  logic signed [23:0] coef_value;

  modport source(output valid, action, channel, sample_in, coef_index, coef_value,
                 input ready);
  modport sink(input valid, action, channel, sample_in, coef_index, coef_value,
               output ready);
endinterface

interface dbq_out_if;
  logic               valid;
  logic               ready;
  logic               channel_out;
  logic signed [15:0] sample_out;

  modport source(output valid, channel_out, sample_out, input ready);
  modport sink(input valid, channel_out, sample_out, output ready);
endinterface

interface dbq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [16:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dbq_mac.sv */
// Shared signed multiply-accumulate unit with round-half-up and 32-bit saturation.
// Depends on dbq_pkg for the command struct and accumulator width.
`timescale 1ns / 1ps
`default_nettype none

module dbq_mac import dbq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mac_cmd_t           cmd_i,
  output logic signed [31:0] res_o
);

  localparam logic signed [ACC_W-1:0] MAX32 = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] MIN32 = -MAX32 - ACC_W'(1);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [4:0]              shift_q;
  logic signed [56:0]      prod;
  logic signed [ACC_W-1:0] rnd, shd;

  assign prod  = cmd_i.a * cmd_i.b;
  assign acc_d = (cmd_i.clr ? cmd_i.init : acc_q) + ACC_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      shift_q <= SH_Q16;
    end else if (cmd_i.en) begin
      acc_q   <= acc_d;
      shift_q <= cmd_i.shift;
    end
  end

  always_comb begin
    rnd = acc_q + (ACC_W'(1) << (shift_q - 5'd1));
    shd = rnd >>> shift_q;
    if (shd > MAX32) begin
      res_o = 32'sh7FFF_FFFF;
    end else if (shd < MIN32) begin
      res_o = 32'sh8000_0000;
    end else begin
      res_o = shd[31:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dbq_div.sv */
// Restoring divider for the thermal gain, one quotient bit per cycle.
// Depends on dbq_pkg for the temperature constants.
`timescale 1ns / 1ps
`default_nettype none

module dbq_div import dbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [10:0] temp_i,
  output logic        done_o,
  output logic [16:0] quot_o
);

  localparam int NUM_W = 23;

  logic             busy_q, done_q;
  logic [4:0]       cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [10:0]      den_q, rem_q, den;
  logic [11:0]      rs;
  logic             ge;

  assign den = temp_i - 11'(TEMP_OFS);
  assign rs  = {rem_q, num_q[NUM_W-1]};
  assign ge  = rs >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      cnt_q  <= 5'(NUM_W);
      busy_q <= (temp_i >= 11'(TEMP_KNEE));
      done_q <= (temp_i < 11'(TEMP_KNEE));
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den;
      if (temp_i < 11'(TEMP_KNEE)) begin
        num_q <= NUM_W'(UNITY16);
      end else begin
        num_q <= NUM_W'(THERM_NUM) + NUM_W'(den >> 1);
      end
    end else if (busy_q) begin
      rem_q <= ge ? 11'(rs - {1'b0, den_q}) : 11'(rs);
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q[16:0];

endmodule

`default_nettype wire

/* hw/rtl/drive_biquad_eq_mix_limiter_core.sv */
// Drive stage, cascaded biquad equalizer, wet/dry mix, gain and soft limiter.
// A sample word runs from acceptance through the drive, biquad, mix, gain, thermal and,
// past the knee, soft-clip steps to a valid result; no new word is taken until that
// result is registered. All multiplies share one multiply-accumulate unit.
// Coefficient-write words give no result.
// Asynchronous active-low reset clears history and coefficients and returns the
// configuration to its reset values (unity master gain, everything else zero).
`timescale 1ns / 1ps
`default_nettype none

module drive_biquad_eq_mix_limiter_core import dbq_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  dbq_cfg_if.sink   cfg_i,
  dbq_in_if.sink    in_i,
  dbq_out_if.source out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_DRIVE, S_DRVL, S_TISS, S_TOUT, S_BIQ, S_BUPD,
    S_BLD0, S_BLD1, S_BLDL, S_MIX0, S_MIX1, S_MIXL,
    S_GAIN, S_GAINL, S_THERM, S_THERML, S_CLIP, S_CLIPM, S_CLIPL, S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [16:0] drive_q, wet_q, mix_q;
  logic [15:0] master_q;
  logic [10:0] temp_q;
  logic [16:0] cfg_sat;

  // Filter state.
  logic signed [31:0] hist_q [CHANNELS][BANDS][4];
  logic signed [23:0] coef_q [COEF_N];

  // Working registers.
  logic signed [15:0] dry_q;
  logic               chan_bit_q;
  logic [CH_W-1:0]    ch_q;
  logic [BAND_W-1:0]  band_q;
  logic [2:0]         k_q;
  logic signed [31:0] x_q;
  logic signed [23:0] targ_q;
  logic               tneg_q, clip_phase_q, cneg_q;
  logic               out_valid_q, out_chan_q;
  logic signed [15:0] out_sample_q;

  mac_cmd_t           mac_cmd;
  logic signed [31:0] res;
  logic               div_done;
  logic [16:0]        div_quot;
  logic               acc_sample, acc_coef;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign acc_sample  = in_i.valid && in_i.ready && !in_i.action;
  assign acc_coef    = in_i.valid && in_i.ready && in_i.action;

  assign out_o.valid       = out_valid_q;
  assign out_o.channel_out = out_chan_q;
  assign out_o.sample_out  = out_sample_q;

  assign cfg_sat = (cfg_i.data > 17'(UNITY16)) ? 17'(UNITY16) : cfg_i.data;

  dbq_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .res_o  (res)
  );

  // The thermal divisor only depends on the temperature, so the divider runs
  // alongside the filter work and is long done by the time its result is needed.
  dbq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_sample),
    .temp_i  (temp_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Table tanh: index and fraction of the magnitude of the held argument.
  logic [23:0]        tmag;
  logic               tbig;
  logic [4:0]         tidx, tidx_hi;
  logic [12:0]        tfrac;
  logic [15:0]        tlo, thi;
  logic signed [16:0] tdiff;

  always_comb begin
    tmag    = targ_q[23] ? 24'(-targ_q) : 24'(targ_q);
    tbig    = tmag >= 24'(TANH_LIMIT);
    tidx    = tbig ? 5'd16 : {1'b0, tmag[16:13]};
    tidx_hi = tbig ? 5'd16 : tidx + 5'd1;
    tfrac   = tbig ? 13'd0 : tmag[12:0];
    tlo     = tanh_tab(tidx);
    thi     = tanh_tab(tidx_hi);
    tdiff   = $signed({1'b0, thi}) - $signed({1'b0, tlo});
  end

  // Soft-clip argument: 20 times the excess over the knee, excess capped.
  logic               clip_neg;
  logic signed [32:0] cx, cmag, cexc;
  logic [17:0]        ccap;
  logic [23:0]        carg;

  always_comb begin
    clip_neg = x_q < -32'(CLIP_KNEE);
    cx       = {x_q[31], x_q};
    cmag     = clip_neg ? -cx : cx;
    cexc     = cmag - 33'(CLIP_KNEE);
    ccap     = (cexc > 33'(TANH_LIMIT)) ? 18'(TANH_LIMIT) : 18'(cexc);
    carg     = {2'b0, ccap, 4'b0} + {4'b0, ccap, 2'b0};
  end

  // Operands of the biquad tap selected by band and tap counters.
  logic [COEF_W-1:0]  caddr;
  logic [1:0]         hidx;
  logic signed [23:0] coef_rd;
  logic signed [31:0] hist_rd;
  logic [18:0]        drive_gain;

  assign caddr      = COEF_W'(32'(band_q) * 5 + 32'(k_q));
  assign hidx       = 2'(k_q - 3'd1);
  assign coef_rd    = coef_q[caddr];
  assign hist_rd    = hist_q[ch_q][band_q][hidx];
  assign drive_gain = 19'(UNITY16) + {2'b0, drive_q} + {1'b0, drive_q, 1'b0};

  // Command for the shared unit in each state.
  always_comb begin
    mac_cmd = '0;
    case (state_q)
      S_DRIVE: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.clr   = 1'b1;
        mac_cmd.a     = 32'(dry_q);
        mac_cmd.b     = $signed({6'b0, drive_gain});
        mac_cmd.shift = SH_Q16;
      end
      S_TISS: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.clr   = 1'b1;
        mac_cmd.init  = {{(ACC_W - 29){1'b0}}, tlo, 13'd0};
        mac_cmd.a     = 32'(tdiff);
        mac_cmd.b     = $signed({12'b0, tfrac});
        mac_cmd.shift = SH_TANH;
      end
      S_BIQ: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.clr   = (k_q == 3'd0);
        mac_cmd.a     = (k_q == 3'd0) ? x_q : hist_rd;
        mac_cmd.b     = (k_q >= 3'd3) ? -$signed({coef_rd[23], coef_rd})
                                      : $signed({coef_rd[23], coef_rd});
        mac_cmd.shift = SH_BIQ;
      end
      S_BLD0, S_MIX0: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.clr   = 1'b1;
        mac_cmd.a     = 32'(dry_q);
        mac_cmd.b     = $signed({8'b0, 17'(UNITY16) - ((state_q == S_BLD0) ? wet_q : mix_q)});
        mac_cmd.shift = SH_Q16;
      end
      S_BLD1, S_MIX1: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.a     = x_q;
        mac_cmd.b     = $signed({8'b0, (state_q == S_BLD1) ? wet_q : mix_q});
        mac_cmd.shift = SH_Q16;
      end
      S_GAIN: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.clr   = 1'b1;
        mac_cmd.a     = x_q;
        mac_cmd.b     = $signed({9'b0, master_q});
        mac_cmd.shift = SH_GAIN;
      end
      S_THERM: begin
        mac_cmd.en    = div_done;
        mac_cmd.clr   = 1'b1;
        mac_cmd.a     = x_q;
        mac_cmd.b     = $signed({8'b0, div_quot});
        mac_cmd.shift = SH_Q16;
      end
      S_CLIPM: begin
        mac_cmd.en    = 1'b1;
        mac_cmd.clr   = 1'b1;
        mac_cmd.a     = x_q;
        mac_cmd.b     = 25'(CLIP_SPAN);
        mac_cmd.shift = SH_CLIP;
      end
      default: begin
        mac_cmd = '0;
      end
    endcase
  end

  // Final value clamped to the 16-bit output range.
  logic signed [15:0] x_sat16;
  logic signed [31:0] clip_r;

  assign x_sat16 = (x_q > 32'sd32767)  ? 16'sh7FFF :
                   (x_q < -32'sd32768) ? 16'sh8000 : x_q[15:0];
  assign clip_r  = res + 32'(CLIP_KNEE);

  // Sequencer, configuration, filter state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      drive_q      <= '0;
      wet_q        <= '0;
      mix_q        <= '0;
      master_q     <= 16'd4096;
      temp_q       <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int b = 0; b < BANDS; b++) begin
          for (int h = 0; h < 4; h++) begin
            hist_q[c][b][h] <= '0;
          end
        end
      end
      for (int i = 0; i < COEF_N; i++) begin
        coef_q[i] <= '0;
      end
      dry_q        <= '0;
      chan_bit_q   <= 1'b0;
      ch_q         <= '0;
      band_q       <= '0;
      k_q          <= '0;
      x_q          <= '0;
      targ_q       <= '0;
      tneg_q       <= 1'b0;
      clip_phase_q <= 1'b0;
      cneg_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_chan_q   <= 1'b0;
      out_sample_q <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_DRIVE:  drive_q  <= cfg_sat;
          CFG_WET:    wet_q    <= cfg_sat;
          CFG_MIX:    mix_q    <= cfg_sat;
          CFG_MASTER: master_q <= cfg_i.data[15:0];
          CFG_TEMP:   temp_q   <= cfg_i.data[10:0];
          default: begin
          end
        endcase
      end

      // The output state updates the valid flag itself; elsewhere a taken word clears it.
      if (out_valid_q && out_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (acc_coef) begin
            if (32'(in_i.coef_index) < COEF_N) begin
              coef_q[COEF_W'(in_i.coef_index)] <= in_i.coef_value;
            end
          end else if (acc_sample) begin
            dry_q        <= in_i.sample_in;
            chan_bit_q   <= in_i.channel;
            ch_q         <= (CHANNELS == 1) ? '0 : CH_W'(in_i.channel);
            band_q       <= '0;
            k_q          <= '0;
            clip_phase_q <= 1'b0;
            state_q      <= S_DRIVE;
          end
        end
        S_DRIVE: state_q <= S_DRVL;
        S_DRVL: begin
          targ_q  <= res[23:0];
          state_q <= S_TISS;
        end
        S_TISS: begin
          tneg_q  <= targ_q[23];
          state_q <= S_TOUT;
        end
        S_TOUT: begin
          if (clip_phase_q) begin
            x_q     <= res;
            state_q <= S_CLIPM;
          end else begin
            x_q     <= tneg_q ? -res : res;
            state_q <= S_BIQ;
          end
        end
        S_BIQ: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) begin
            state_q <= S_BUPD;
          end
        end
        S_BUPD: begin
          // Direct form I shift: the band's input and output histories move one step.
          hist_q[ch_q][band_q][1] <= hist_q[ch_q][band_q][0];
          hist_q[ch_q][band_q][0] <= x_q;
          hist_q[ch_q][band_q][3] <= hist_q[ch_q][band_q][2];
          hist_q[ch_q][band_q][2] <= res;
          x_q <= res;
          k_q <= '0;
          if (band_q == BAND_W'(BANDS - 1)) begin
            state_q <= S_BLD0;
          end else begin
            band_q  <= band_q + BAND_W'(1);
            state_q <= S_BIQ;
          end
        end
        S_BLD0: state_q <= S_BLD1;
        S_BLD1: state_q <= S_BLDL;
        S_BLDL: begin
          x_q     <= res;
          state_q <= S_MIX0;
        end
        S_MIX0: state_q <= S_MIX1;
        S_MIX1: state_q <= S_MIXL;
        S_MIXL: begin
          x_q     <= res;
          state_q <= S_GAIN;
        end
        S_GAIN: state_q <= S_GAINL;
        S_GAINL: begin
          x_q     <= res;
          state_q <= S_THERM;
        end
        S_THERM: begin
          if (div_done) begin
            state_q <= S_THERML;
          end
        end
        S_THERML: begin
          x_q     <= res;
          state_q <= S_CLIP;
        end
        S_CLIP: begin
          // Past the knee on either side the excess goes through the tanh table;
          // the negative side mirrors the positive one.
          if (x_q > 32'(CLIP_KNEE) || clip_neg) begin
            cneg_q       <= clip_neg;
            targ_q       <= $signed(carg);
            clip_phase_q <= 1'b1;
            state_q      <= S_TISS;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_CLIPM: state_q <= S_CLIPL;
        S_CLIPL: begin
          x_q     <= cneg_q ? -clip_r : clip_r;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_chan_q   <= chan_bit_q;
            out_sample_q <= x_sat16;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A sample word always starts the drive stage on the next cycle.
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_sample |=> state_q == S_DRIVE)
    else $error("sample word did not start processing");

  // A coefficient word leaves the block idle.
  a_coef_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_coef |=> state_q == S_IDLE)
    else $error("coefficient word left the idle state");

  // A new result only appears from the output state.
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(state_q == S_OUT))
    else $error("result appeared outside the output state");

  // The thermal multiply only runs on a finished quotient.
  a_therm_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_THERML |-> $past(div_done))
    else $error("thermal gain used before the divider finished");

endmodule

`default_nettype wire

/* tb/sv/tb_drive_biquad_eq_mix_limiter_core.sv */
// Self-checking testbench of the drive/biquad/mix/limiter core: directed and random words,
// results predicted in-line and compared in order. Depends on dbq_pkg, dbq_if.sv and the core.
`timescale 1ns / 1ps

module tb_drive_biquad_eq_mix_limiter_core;
  import dbq_pkg::*;

  // Longest quiet stretch tolerated before the run is declared hung.
  localparam int HANG_LIMIT  = 5000;
  // Settling stretch after the last expected result, before a register write.
  localparam int SETTLE_CYC  = 60;
  localparam int RANDOM_WORDS = 1150;

  typedef struct {
    logic channel;
    logic signed [15:0] sample;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dbq_cfg_if cfg_if ();
  dbq_in_if in_if ();
  dbq_out_if out_if ();

  drive_biquad_eq_mix_limiter_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Shadow copy of the block state used by the predictor.
  longint hist[CHANNELS][BANDS][4];
  longint coefs[COEF_N];
  longint drive_q16, wet_q16, mix_q16, master_q12, temp_tenths;

  result_t expected_results[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit hold_ready = 1'b0;

  // tanh(k/4) in Q.15, the knots of the drive and soft-clip curves.
  const longint TANH_KNOTS[17] = '{0, 8026, 15143, 20813, 24957, 27797, 29660, 30847, 31589,
                                   32048, 32329, 32500, 32606, 32670, 32708, 32732, 32746};

  // Arithmetic right shift floors, so adding half an LSB first rounds half up.
  function automatic longint rnd_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint tanh_q15(longint x);
    longint m, y, frac;
    int k;
    m = (x < 0) ? -x : x;
    if (m >= TANH_LIMIT) begin
      y = TANH_KNOTS[16];
    end else begin
      k = int'(m >>> 13);
      frac = m & 8191;
      y = TANH_KNOTS[k] + (((TANH_KNOTS[k+1] - TANH_KNOTS[k]) * frac + 4096) >>> 13);
    end
    return (x < 0) ? -y : y;
  endfunction

  // Positive half of the limiter; the negative half mirrors it.
  function automatic longint knee_curve(longint v);
    longint e;
    e = v - CLIP_KNEE;
    if (e > TANH_LIMIT) e = TANH_LIMIT;
    return CLIP_KNEE + rnd_shift(CLIP_SPAN * tanh_q15(e * 20), 15);
  endfunction

  function automatic longint thermal_q16();
    longint d;
    if (temp_tenths < TEMP_KNEE) return UNITY16;
    d = temp_tenths - TEMP_OFS;
    return (THERM_NUM + d / 2) / d;
  endfunction

  // Updates the shadow state for one accepted word and queues its result, if any.
  function automatic void model_word(logic action, logic chan, logic signed [15:0] smp,
                                     logic [4:0] idx, logic signed [23:0] cval);
    longint dry, x, acc, y, blend, mixd, v;
    int ch;
    result_t r;
    if (action) begin
      if (idx < COEF_N) coefs[idx] = cval;
      return;
    end
    ch = int'(chan) % CHANNELS;
    dry = smp;
    x = tanh_q15(rnd_shift(dry * (UNITY16 + 3 * drive_q16), 16));
    for (int b = 0; b < BANDS; b++) begin
      acc = coefs[5*b] * x + coefs[5*b+1] * hist[ch][b][0] + coefs[5*b+2] * hist[ch][b][1]
          - coefs[5*b+3] * hist[ch][b][2] - coefs[5*b+4] * hist[ch][b][3];
      y = clamp32(rnd_shift(acc, 20));
      hist[ch][b][1] = hist[ch][b][0];
      hist[ch][b][0] = x;
      hist[ch][b][3] = hist[ch][b][2];
      hist[ch][b][2] = y;
      x = y;
    end
    blend = clamp32(rnd_shift(dry * (UNITY16 - wet_q16) + x * wet_q16, 16));
    mixd = clamp32(rnd_shift(dry * (UNITY16 - mix_q16) + blend * mix_q16, 16));
    v = clamp32(rnd_shift(mixd * master_q12, 12));
    v = clamp32(rnd_shift(v * thermal_q16(), 16));
    if (v > CLIP_KNEE) v = knee_curve(v);
    else if (v < -CLIP_KNEE) v = -knee_curve(-v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    r.channel = chan;
    r.sample = 16'(v);
    expected_results.push_back(r);
  endfunction

  // Sends one word with the sender's burst/gap pattern; returns right after acceptance.
  task automatic send_word(logic action, logic chan, logic signed [15:0] smp,
                           logic [4:0] idx, logic signed [23:0] cval);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid = 1'b1;
    in_if.action = action;
    in_if.channel = chan;
    in_if.sample_in = smp;
    in_if.coef_index = idx;
    in_if.coef_value = cval;
    do @(posedge clk_i); while (!in_if.ready);
    model_word(action, chan, smp, idx, cval);
  endtask

  task automatic send_sample(logic chan, logic signed [15:0] smp);
    send_word(1'b0, chan, smp, 5'($urandom), 24'($urandom));
  endtask

  task automatic send_coef(logic [4:0] idx, logic signed [23:0] cval);
    send_word(1'b1, 1'($urandom), 16'($urandom), idx, cval);
  endtask

  // Lets every expected word drain and the block fall silent.
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [16:0] value);
    logic [16:0] sat17;
    wait_idle();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = value;
    do @(posedge clk_i); while (!cfg_if.ready);
    sat17 = (value > UNITY16) ? 17'(UNITY16) : value;
    case (idx)
      CFG_DRIVE:  drive_q16 = sat17;
      CFG_WET:    wet_q16 = sat17;
      CFG_MIX:    mix_q16 = sat17;
      CFG_MASTER: master_q12 = value[15:0];
      CFG_TEMP:   temp_tenths = value[10:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_all(logic [16:0] drv, logic [16:0] wet, logic [16:0] mix,
                         logic [16:0] gain, logic [16:0] temp);
    write_reg(CFG_DRIVE, drv);
    write_reg(CFG_WET, wet);
    write_reg(CFG_MIX, mix);
    write_reg(CFG_MASTER, gain);
    write_reg(CFG_TEMP, temp);
  endtask

  // Loads one band with coefficients whose feedback stays stable (|a1|+|a2| < 1).
  task automatic load_stable_band(int band);
    send_coef(5'(5*band),     24'($urandom_range(0, 2097152)) - 24'sd1048576);
    send_coef(5'(5*band + 1), 24'($urandom_range(0, 1048576)) - 24'sd524288);
    send_coef(5'(5*band + 2), 24'($urandom_range(0, 1048576)) - 24'sd524288);
    send_coef(5'(5*band + 3), 24'($urandom_range(0, 1048576)) - 24'sd524288);
    send_coef(5'(5*band + 4), 24'($urandom_range(0, 524288)) - 24'sd262144);
  endtask

  // With cleared coefficients and wet at zero the path is drive-free and the block is
  // close to a pass-through; this checks the reset gain and temperature values.
  task automatic test_reset_state();
    send_sample(1'b0, 16'sd0);
    send_sample(1'b1, 16'sd12345);
    send_sample(1'b0, -16'sd20000);
    send_sample(1'b1, 16'sh7FFF);
    send_sample(1'b0, 16'sh8000);
  endtask

  // Unity pass-through bands, then the full-scale drive, wet, mix and gain so that
  // both sides of the soft clip and the out-of-range coefficient indices are hit.
  task automatic test_extremes();
    for (int b = 0; b < BANDS; b++) begin
      send_coef(5'(5*b), 24'sd1048576);
      send_coef(5'(5*b + 3), 24'sh800000);
      send_coef(5'(5*b + 3), 24'sd0);
    end
    send_coef(5'd20, 24'sh7FFFFF);
    send_coef(5'd31, 24'sh800000);
    set_all(17'h1FFFF, 17'h1FFFF, 17'd65536, 17'hFFFF, 17'd0);
    send_sample(1'b0, 16'sh7FFF);
    send_sample(1'b1, 16'sh8000);
    send_sample(1'b0, 16'sd1);
    send_sample(1'b1, -16'sd1);
    send_sample(1'b0, 16'sd3000);
    set_all(17'd0, 17'd0, 17'd0, 17'd0, 17'd2047);
    send_sample(1'b1, 16'sh7FFF);
    set_all(17'd32768, 17'd65536, 17'd65535, 17'd8192, 17'd420);
    send_sample(1'b0, 16'sh7FFF);
    send_sample(1'b1, 16'sh8000);
    write_reg(CFG_TEMP, 17'd1500);
    send_sample(1'b0, -16'sd16000);
  endtask

  // Random phases, each under a fresh register setting. Most words are samples through
  // stable filters; a few are stray coefficient writes with any value or index.
  task automatic test_random();
    int per_phase, stamp;
    per_phase = RANDOM_WORDS / 6;
    for (int ph = 0; ph < 6; ph++) begin
      set_all(17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
              (ph % 2) ? 17'($urandom_range(380, 1500)) : 17'($urandom));
      for (int b = 0; b < BANDS; b++) load_stable_band(b);
      for (int n = 0; n < per_phase; n++) begin
        stamp = $urandom_range(0, 99);
        if (stamp < 2) begin
          send_coef(5'($urandom), 24'($urandom));
        end else if (stamp < 6) begin
          load_stable_band($urandom_range(0, BANDS - 1));
        end else if (stamp < 7) begin
          // Sender holds off until the block has delivered everything.
          @(negedge clk_i);
          in_if.valid = 1'b0;
          while (expected_results.size() != 0) @(negedge clk_i);
        end else begin
          send_sample(1'($urandom), 16'($urandom));
        end
      end
    end
  endtask

  // Receiver stalls on its own pattern; some stretches keep ready high throughout.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) hold_ready <= ~hold_ready;
    out_if.ready <= hold_ready ? 1'b1 : ($urandom_range(0, 2) != 0);
  end

  // Result checker and hang watchdog, both sampled at the rising edge.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: ch %0d sample %0d", out_if.channel_out,
                     out_if.sample_out);
        end else begin
          want = expected_results.pop_front();
          if (want.channel !== out_if.channel_out || want.sample !== out_if.sample_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
                       want.channel, want.sample, out_if.channel_out, out_if.sample_out);
          end
        end
      end
    end
  end

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_DRIVE;
    cfg_if.data = '0;
    in_if.valid = 1'b0;
    in_if.action = 1'b0;
    in_if.channel = 1'b0;
    in_if.sample_in = '0;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    out_if.ready = 1'b0;
    foreach (hist[c, b, k]) hist[c][b][k] = 0;
    foreach (coefs[i]) coefs[i] = 0;
    drive_q16 = 0;
    wet_q16 = 0;
    mix_q16 = 0;
    master_q12 = 4096;
    temp_tenths = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_extremes();
    test_random();
    wait_idle();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
